// ===== hw/rtl/mpcv_pkg.sv =====
// shared types, constants and functions for the merkle proof claim verifier
// no dependencies
`default_nettype none

package mpcv_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;
  typedef word_t [7:0] cv_t;

  localparam int unsigned MAX_LEVELS = 32;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_VALID = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_ROOT = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic CMD_BEGIN = 1'b0;

  // domain tags, 9 bytes each
  localparam logic [71:0] TAG_LEAF = 72'h50_59_44_45_5F_4C_45_41_46;
  localparam logic [71:0] TAG_NODE = 72'h50_59_44_45_5F_4E_4F_44_45;

  // compression block lengths and flags
  localparam word_t LEAF_BLEN = 32'd57;
  localparam word_t LEAF_FLAGS = 32'd11;
  localparam word_t NODE_BLEN0 = 32'd64;
  localparam word_t NODE_FLAGS0 = 32'd1;
  localparam word_t NODE_BLEN1 = 32'd9;
  localparam word_t NODE_FLAGS1 = 32'd10;

  localparam word_t IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [3:0] PERM [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};

  // half-round counter: 7 rounds of column and diagonal halves
  localparam int unsigned HALF_ROUNDS = 14;
  localparam int unsigned HR_W = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FIN,
    S_DONE
  } state_e;

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // quarter-round mixing, returns {a, b, c, d}
  function automatic logic [127:0] g_mix(word_t a, word_t b, word_t c, word_t d,
                                         word_t mx, word_t my);
    word_t ta, tb, tc, td;
    ta = a + b + mx;
    td = rotr(d ^ ta, 16);
    tc = c + td;
    tb = rotr(b ^ tc, 12);
    ta = ta + tb + my;
    td = rotr(td ^ ta, 8);
    tc = tc + td;
    tb = rotr(tb ^ tc, 7);
    g_mix = {ta, tb, tc, td};
  endfunction

  // little-endian message words of one 64-byte block of a big-endian byte string
  function automatic state_t block_words(logic [1023:0] msg, logic blk);
    state_t w;
    int unsigned j;
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 4; k++) begin
        j = 64 * 32'(blk) + 4 * i + k;
        w[i][8*k +: 8] = msg[1023 - 8*j -: 8];
      end
    end
    block_words = w;
  endfunction

  // chaining value to big-endian 32-byte hash
  function automatic logic [255:0] cv_to_hash(cv_t cv);
    logic [255:0] h;
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 4; k++) begin
        h[255 - 8*(4*i + k) -: 8] = cv[i][8*k +: 8];
      end
    end
    cv_to_hash = h;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mpcv_if.sv =====
// valid/ready channel interfaces for claim words and result words
// depends on nothing
`default_nettype none

interface mpcv_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] data_word0;
  logic [63:0] data_word1;
  logic [63:0] data_word2;
  logic [63:0] data_word3;
  logic [63:0] amount_high;
  logic [63:0] amount_low;
  logic [7:0]  position;
  logic        last;

  modport source (output valid, command, data_word0, data_word1, data_word2, data_word3,
                  amount_high, amount_low, position, last, input ready);
  modport sink (input valid, command, data_word0, data_word1, data_word2, data_word3,
                amount_high, amount_low, position, last, output ready);
endinterface

interface mpcv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] total_high;
  logic [63:0] total_low;

  modport source (output valid, status, total_high, total_low, input ready);
  modport sink (input valid, status, total_high, total_low, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/merkle_proof_claim_verifier.sv =====
// top level: claim sequencer, hash state, root registers and running total
// depends on mpcv_pkg, mpcv_if, mpcv_half_round
//
// channel   dir  words
// in_s      in   command, data_word0..3, amount_high/low, position, last
// out_s     out  status, total_high, total_low
//
// one half-round of mixing per cycle; a compression runs S_LOAD, the S_ROUND half-rounds, then S_FIN
// a begin word takes one compression, a proof step two
// a step past the level limit skips hashing and goes to S_DONE; in_s.ready is high only when idle
// the result register holds a word until taken; a final word waits for it
// reset clears control, hash, counters, total and root registers

`default_nettype none

module merkle_proof_claim_verifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mpcv_in_if.sink                       in_s,
  mpcv_out_if.source                    out_s,
  input  logic                          cfg_we_i,
  input  logic [mpcv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_data_i
);
  import mpcv_pkg::*;

  state_e state_q, state_d;
  logic [HR_W-1:0] hr_q, hr_d;
  logic blk_q, blk_d;
  state_t s_q, s_d, m_q, m_d, s_mix;
  cv_t cv_q, cv_d, cv_fin;
  logic [255:0] hash_q, hash_d;
  logic [255:0] root_q;
  logic root_valid_q;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic too_long_q, too_long_d;
  logic [127:0] pend_q, pend_d;
  logic [127:0] total_q, total_d;
  logic cmd_q, last_q, right_q;
  logic [255:0] data_q;
  logic out_valid_q, out_valid_d;
  logic [2:0] out_status_q, out_status_d;
  logic [127:0] out_total_q, out_total_d;
  logic accept;
  logic [1023:0] msg;
  logic [128:0] sum;

  assign accept = in_s.valid && in_s.ready;
  assign in_s.ready = (state_q == S_IDLE);
  assign out_s.valid = out_valid_q;
  assign out_s.status = out_status_q;
  assign out_s.total_high = out_total_q[127:64];
  assign out_s.total_low = out_total_q[63:0];

  // message for the current word
  always_comb begin
    if (cmd_q == CMD_BEGIN) begin
      msg = {TAG_LEAF, data_q, pend_q, 568'd0};
    end else if (right_q) begin
      msg = {TAG_NODE, data_q, hash_q, 440'd0};
    end else begin
      msg = {TAG_NODE, hash_q, data_q, 440'd0};
    end
  end

  mpcv_half_round u_mix (
    .s_i    (s_q),
    .m_i    (m_q),
    .diag_i (hr_q[0]),
    .s_o    (s_mix)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cv_fin[i] = s_q[i] ^ s_q[i + 8];
    end
  end

  assign sum = {1'b0, total_q} + {1'b0, pend_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    hr_d = hr_q;
    blk_d = blk_q;
    s_d = s_q;
    m_d = m_q;
    cv_d = cv_q;
    hash_d = hash_q;
    level_d = level_q;
    too_long_d = too_long_q;
    pend_d = pend_q;
    total_d = total_q;
    out_valid_d = out_valid_q && !out_s.ready;
    out_status_d = out_status_q;
    out_total_d = out_total_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          blk_d = 1'b0;
          for (int i = 0; i < 8; i++) cv_d[i] = IV[i];
          if (in_s.command == CMD_BEGIN) begin
            pend_d = {in_s.amount_high, in_s.amount_low};
            level_d = '0;
            too_long_d = 1'b0;
            state_d = S_LOAD;
          end else if (32'(level_q) >= MAX_LEVELS) begin
            too_long_d = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        m_d = block_words(msg, blk_q);
        for (int i = 0; i < 8; i++) s_d[i] = cv_q[i];
        for (int i = 0; i < 4; i++) s_d[8 + i] = IV[i];
        s_d[12] = '0;
        s_d[13] = '0;
        if (cmd_q == CMD_BEGIN) begin
          s_d[14] = LEAF_BLEN;
          s_d[15] = LEAF_FLAGS;
        end else if (!blk_q) begin
          s_d[14] = NODE_BLEN0;
          s_d[15] = NODE_FLAGS0;
        end else begin
          s_d[14] = NODE_BLEN1;
          s_d[15] = NODE_FLAGS1;
        end
        hr_d = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        s_d = s_mix;
        // message permutation after each full round
        if (hr_q[0]) begin
          for (int i = 0; i < 16; i++) m_d[i] = m_q[PERM[i]];
        end
        hr_d = hr_q + 1'b1;
        if (32'(hr_q) == HALF_ROUNDS - 1) state_d = S_FIN;
      end
      S_FIN: begin
        cv_d = cv_fin;
        if (cmd_q != CMD_BEGIN && !blk_q) begin
          blk_d = 1'b1;
          state_d = S_LOAD;
        end else begin
          hash_d = cv_to_hash(cv_fin);
          if (cmd_q != CMD_BEGIN) level_d = level_q + 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || out_s.ready) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          if (!root_valid_q) begin
            out_status_d = ST_NO_ROOT;
          end else if (too_long_q) begin
            out_status_d = ST_TOO_LONG;
          end else if (hash_q != root_q) begin
            out_status_d = ST_INVALID;
          end else if (sum[128]) begin
            out_status_d = ST_OVERFLOW;
          end else begin
            out_status_d = ST_OK;
            total_d = sum[127:0];
            out_total_d = sum[127:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hr_q <= '0;
      blk_q <= 1'b0;
      hash_q <= '0;
      level_q <= '0;
      too_long_q <= 1'b0;
      total_q <= '0;
      out_valid_q <= 1'b0;
      root_q <= '0;
      root_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hr_q <= hr_d;
      blk_q <= blk_d;
      hash_q <= hash_d;
      level_q <= level_d;
      too_long_q <= too_long_d;
      total_q <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROOT0: root_q[255:192] <= cfg_data_i;
          CFG_ROOT1: root_q[191:128] <= cfg_data_i;
          CFG_ROOT2: root_q[127:64] <= cfg_data_i;
          CFG_ROOT3: root_q[63:0] <= cfg_data_i;
          CFG_ROOT_VALID: root_valid_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    m_q <= m_d;
    cv_q <= cv_d;
    pend_q <= pend_d;
    out_status_q <= out_status_d;
    out_total_q <= out_total_d;
    if (accept) begin
      cmd_q <= in_s.command;
      last_q <= in_s.last;
      right_q <= (in_s.position != 8'd0);
      data_q <= {in_s.data_word0, in_s.data_word1, in_s.data_word2, in_s.data_word3};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpcv_half_round.sv =====
// shared mixing unit: one column or diagonal half-round of four g functions
// depends on mpcv_pkg
`default_nettype none

module mpcv_half_round (
  input  mpcv_pkg::state_t s_i,
  input  mpcv_pkg::state_t m_i,
  input  logic             diag_i,
  output mpcv_pkg::state_t s_o
);
  import mpcv_pkg::*;

  always_comb begin
    logic [127:0] r;
    int unsigned ia, ib, ic, id, im;
    s_o = s_i;
    for (int k = 0; k < 4; k++) begin
      // lane k picks its four state words and two message words
      ia = k;
      ib = diag_i ? 4 + ((k + 1) % 4) : 4 + k;
      ic = diag_i ? 8 + ((k + 2) % 4) : 8 + k;
      id = diag_i ? 12 + ((k + 3) % 4) : 12 + k;
      im = diag_i ? 8 + 2 * k : 2 * k;
      r = g_mix(s_i[ia], s_i[ib], s_i[ic], s_i[id], m_i[im], m_i[im + 1]);
      s_o[ia] = r[127:96];
      s_o[ib] = r[95:64];
      s_o[ic] = r[63:32];
      s_o[id] = r[31:0];
    end
  end

endmodule

`default_nettype wire
